// ===== hw/rtl/wlru_pkg.sv =====
// Shared constants, codes and control types of the weighted LRU victim selector.
`timescale 1ns / 1ps

package wlru_pkg;

    localparam int NUM_SETS    = 64;
    localparam int NUM_WAYS    = 8;
    localparam int WEIGHT_BITS = 8;

    localparam int KIND_W   = 2;
    localparam int SET_IN_W = 6;
    localparam int WAY_IN_W = 3;
    localparam int OCC_W    = 8;
    localparam int UP_W     = 8;
    localparam int LEVEL_W  = 2;
    localparam int STAMP_W  = 32;

    localparam int SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WAY_W  = $clog2(NUM_WAYS);
    localparam int LEVELS = $clog2(NUM_WAYS);
    localparam int PAD    = 1 << LEVELS;
    localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;

    localparam logic [KIND_W-1:0] KIND_TOUCH  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INVAL  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_VICTIM = 2'd2;

    localparam logic [LEVEL_W-1:0] LEVEL_ONE = 2'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_TWO = 2'd2;

    typedef struct packed {
        logic latch;
        logic clear_step;
        logic exec_write;
        logic mem_read;
        logic load_cand;
        logic reduce;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic is_victim;
        logic reduce_last;
    } t_status;

endpackage

// ===== hw/rtl/wlru_ctrl.sv =====
// Controller state machine: clearing pass, request sequencing and result slot.
`timescale 1ns / 1ps

module wlru_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  wlru_pkg::t_status i_status,
    output wlru_pkg::t_cmd    o_cmd
);
    import wlru_pkg::*;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_LOAD   = 3'd3;
    localparam logic [2:0] S_REDUCE = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_status.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_status.is_victim) begin
                    o_cmd.mem_read = 1'b1;
                    n_state        = S_LOAD;
                end else begin
                    o_cmd.exec_write = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_LOAD: begin
                o_cmd.load_cand = 1'b1;
                n_state         = S_REDUCE;
            end
            S_REDUCE: begin
                o_cmd.reduce = 1'b1;
                if (i_status.reduce_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_slot_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== hw/rtl/wlru_datapath.sv =====
// Datapath: per-way stamp and weight memories, stamp counter, ranking tree, result register.
`timescale 1ns / 1ps

module wlru_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  wlru_pkg::t_cmd                   i_cmd,
    output wlru_pkg::t_status                o_status,
    input  logic [wlru_pkg::KIND_W-1:0]      i_kind,
    input  logic [wlru_pkg::SET_IN_W-1:0]    i_set_index,
    input  logic [wlru_pkg::WAY_IN_W-1:0]    i_way_index,
    input  logic [wlru_pkg::OCC_W-1:0]       i_occupancy,
    input  logic [wlru_pkg::UP_W-1:0]        i_upper_present,
    input  logic                             i_cfg_valid,
    input  logic [wlru_pkg::LEVEL_W-1:0]     i_cfg_hier_level,
    output logic [wlru_pkg::WAY_IN_W-1:0]    o_victim_way,
    output logic                             o_victim_invalid
);
    import wlru_pkg::*;

    localparam logic [1:0] TIER_INVALID = 2'd0;
    localparam logic [1:0] TIER_ABSENT  = 2'd1;
    localparam logic [1:0] TIER_PRESENT = 2'd2;
    localparam logic [1:0] TIER_PAD     = 2'd3;

    typedef struct packed {
        logic [1:0]             tier;
        logic [WEIGHT_BITS-1:0] weight;
        logic [STAMP_W-1:0]     stamp;
        logic [WAY_W-1:0]       idx;
        logic                   inval;
    } t_cand;

    function automatic t_cand pick(t_cand a, t_cand b);
        t_cand res;
        res = a;
        if ({b.tier, b.weight, b.stamp} < {a.tier, a.weight, a.stamp}) begin
            res = b;
        end
        return res;
    endfunction

    // latched request
    logic [KIND_W-1:0]   r_kind;
    logic [SET_W-1:0]    r_set;
    logic [WAY_IN_W-1:0] r_way;
    logic [OCC_W-1:0]    r_occ;
    logic [UP_W-1:0]     r_upper;
    logic [SET_W-1:0]    w_set_map;

    logic [LEVEL_W-1:0]  r_hier_level;
    logic [STAMP_W-1:0]  r_counter;
    logic [SET_W-1:0]    r_clr_addr;
    logic [LVL_W-1:0]    r_level;

    logic [SET_W-1:0]       w_addr;
    logic                   w_touch;
    logic                   w_inval;
    logic                   w_in_range;
    logic [STAMP_W-1:0]     w_stamp_wd;
    logic [WEIGHT_BITS-1:0] w_weight_wd;
    logic                   w_level_two;

    t_cand w_cand [PAD];
    t_cand r_cand [PAD];
    t_cand n_cand [PAD];

    logic [WAY_IN_W-1:0] r_victim_way;
    logic                r_victim_inv;

    // fold the set field onto the configured number of sets
    generate
        if (NUM_SETS >= (1 << SET_IN_W)) begin : g_set_direct
            assign w_set_map = SET_W'(i_set_index);
        end else begin : g_set_fold
            localparam int RECIP = ((1 << 16) + NUM_SETS - 1) / NUM_SETS;
            logic [SET_IN_W+16:0] w_prod;
            logic [SET_IN_W:0]    w_quot;
            logic [SET_IN_W+6:0]  w_sub;
            logic [SET_IN_W-1:0]  w_rem;
            logic [SET_IN_W-1:0]  w_fix;
            always_comb begin
                w_prod = (SET_IN_W + 17)'(i_set_index) * (SET_IN_W + 17)'(RECIP);
                w_quot = w_prod[SET_IN_W+16:16];
                w_sub  = (SET_IN_W + 7)'(w_quot) * (SET_IN_W + 7)'(NUM_SETS);
                w_rem  = i_set_index - w_sub[SET_IN_W-1:0];
                w_fix  = (w_rem >= SET_IN_W'(NUM_SETS)) ? w_rem - SET_IN_W'(NUM_SETS) : w_rem;
            end
            assign w_set_map = SET_W'(w_fix);
        end
    endgenerate

    assign w_addr      = i_cmd.clear_step ? r_clr_addr : r_set;
    assign w_in_range  = (5'(r_way) < 5'(NUM_WAYS));
    assign w_touch     = i_cmd.exec_write && (r_kind == KIND_TOUCH) && w_in_range;
    assign w_inval     = i_cmd.exec_write && (r_kind == KIND_INVAL) && w_in_range;
    assign w_stamp_wd  = (i_cmd.clear_step || !w_touch) ? '0 : r_counter;
    assign w_weight_wd = i_cmd.clear_step ? '0 : WEIGHT_BITS'(r_occ);
    assign w_level_two = (r_hier_level == LEVEL_TWO);

    generate
        for (genvar g = 0; g < PAD; g++) begin : g_way
            if (g < NUM_WAYS) begin : g_real
                logic [STAMP_W-1:0]     r_stamp_mem  [NUM_SETS];
                logic [WEIGHT_BITS-1:0] r_weight_mem [NUM_SETS];
                logic [STAMP_W-1:0]     r_rd_stamp;
                logic [WEIGHT_BITS-1:0] r_rd_weight;
                logic                   w_hit;
                logic                   w_present;
                logic                   w_empty;

                assign w_hit = (5'(r_way) == 5'(g));
                if (g < UP_W) begin : g_up
                    assign w_present = r_upper[g];
                end else begin : g_noup
                    assign w_present = 1'b0;
                end

                always_ff @(posedge i_clk) begin
                    if (i_cmd.clear_step || (w_hit && (w_touch || w_inval))) begin
                        r_stamp_mem[w_addr] <= w_stamp_wd;
                    end
                    if (i_cmd.clear_step || (w_hit && w_touch)) begin
                        r_weight_mem[w_addr] <= w_weight_wd;
                    end
                    if (i_cmd.mem_read) begin
                        r_rd_stamp  <= r_stamp_mem[w_addr];
                        r_rd_weight <= r_weight_mem[w_addr];
                    end
                end

                // standard mode ranks every invalid way equal, so the lowest wins
                assign w_empty = (r_rd_stamp == '0);
                always_comb begin
                    w_cand[g].idx   = WAY_W'(g);
                    w_cand[g].inval = w_empty;
                    w_cand[g].stamp = r_rd_stamp;
                    if (w_empty) begin
                        w_cand[g].tier   = TIER_INVALID;
                        w_cand[g].weight = w_level_two ? r_rd_weight : '0;
                    end else begin
                        w_cand[g].tier   = (w_level_two && w_present) ? TIER_PRESENT
                                                                      : TIER_ABSENT;
                        w_cand[g].weight = r_rd_weight;
                    end
                end
            end else begin : g_pad
                always_comb begin
                    w_cand[g]       = '0;
                    w_cand[g].tier  = TIER_PAD;
                    w_cand[g].idx   = WAY_W'(g);
                end
            end
        end
    endgenerate

    // one tree level per cycle, lower index kept on a tie
    always_comb begin
        n_cand = r_cand;
        if (i_cmd.load_cand) begin
            n_cand = w_cand;
        end else if (i_cmd.reduce) begin
            for (int i = 0; i < PAD / 2; i++) begin
                n_cand[i] = pick(r_cand[2 * i], r_cand[2 * i + 1]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cand <= n_cand;
        if (i_cmd.latch) begin
            r_kind  <= i_kind;
            r_set   <= w_set_map;
            r_way   <= i_way_index;
            r_occ   <= i_occupancy;
            r_upper <= i_upper_present;
        end
        if (i_cmd.load_out) begin
            r_victim_way <= WAY_IN_W'(r_cand[0].idx);
            r_victim_inv <= r_cand[0].inval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hier_level <= LEVEL_ONE;
            r_counter    <= STAMP_W'(1);
            r_clr_addr   <= '0;
            r_level      <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_hier_level <= i_cfg_hier_level;
            end
            if (w_touch && (r_counter != '1)) begin
                r_counter <= r_counter + STAMP_W'(1);
            end
            if (i_cmd.clear_step) begin
                r_clr_addr <= r_clr_addr + SET_W'(1);
            end
            if (i_cmd.load_cand) begin
                r_level <= '0;
            end else if (i_cmd.reduce) begin
                r_level <= r_level + LVL_W'(1);
            end
        end
    end

    assign o_status.clear_last  = (r_clr_addr == SET_W'(NUM_SETS - 1));
    assign o_status.is_victim   = (r_kind == KIND_VICTIM);
    assign o_status.reduce_last = (r_level == LVL_W'(LEVELS - 1));

    assign o_victim_way     = r_victim_way;
    assign o_victim_invalid = r_victim_inv;

endmodule

// ===== hw/rtl/weighted_lru_victim_select.sv =====
// Top level of the weighted LRU victim selector for a set-associative cache.
// Touch and invalidate requests are latched and written to the addressed way. A victim
// request is latched, its set is read into registers, the candidates are loaded, the
// ranking tree is reduced one level per cycle and the victim goes to the result register.
// One request is in flight at a time; a full result slot holds the next victim.
// Reset starts a clearing pass over all NUM_SETS sets that zeroes all stamps and weights;
// no request is taken until it ends. Configuration writes are taken at any time.
`timescale 1ns / 1ps

module weighted_lru_victim_select (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // request channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [wlru_pkg::KIND_W-1:0]      i_kind,
    input  logic [wlru_pkg::SET_IN_W-1:0]    i_set_index,
    input  logic [wlru_pkg::WAY_IN_W-1:0]    i_way_index,
    input  logic [wlru_pkg::OCC_W-1:0]       i_occupancy,
    input  logic [wlru_pkg::UP_W-1:0]        i_upper_present,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [wlru_pkg::WAY_IN_W-1:0]    o_victim_way,
    output logic                             o_victim_invalid,
    // configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [wlru_pkg::LEVEL_W-1:0]     i_cfg_hier_level
);
    import wlru_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    // the level register takes a write in any cycle
    assign o_cfg_ready = 1'b1;

    // Sequence each request: clear sets after reset, latch a request, then either
    // write the addressed way or read the set and walk the ranking tree.
    wlru_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // Hold the stamp and weight stores, the stamp counter and the result register.
    // The result register parts the request side from the result side, so a new
    // request is taken while the previous victim still waits to be taken.
    wlru_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_kind            (i_kind),
        .i_set_index       (i_set_index),
        .i_way_index       (i_way_index),
        .i_occupancy       (i_occupancy),
        .i_upper_present   (i_upper_present),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_hier_level  (i_cfg_hier_level),
        .o_victim_way      (o_victim_way),
        .o_victim_invalid  (o_victim_invalid)
    );

endmodule

// ===== hw/rtl/wlru_checker.sv =====
// Port-level checker for the weighted LRU victim selector, bound to the top level.
`timescale 1ns / 1ps

module wlru_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic [wlru_pkg::KIND_W-1:0]   i_kind,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [wlru_pkg::WAY_IN_W-1:0] o_victim_way,
    input logic                          o_victim_invalid
);
    import wlru_pkg::*;

    logic w_in_acc;
    assign w_in_acc = i_in_valid && o_in_ready;

    // a waiting result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_victim_way)
                                           && $stable(o_victim_invalid)))
        else $error("result changed while stalled");

    // one request at a time
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !o_in_ready)
        else $error("request taken while busy");

    // a non-victim request frees the request side as soon as its write is done
    a_write_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_kind != KIND_VICTIM)) |=> !o_in_ready ##1 o_in_ready)
        else $error("write request did not complete in two cycles");

    // reset drops the result and holds off requests at the start of the clearing pass
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_ready))
        else $error("not quiet after reset");

endmodule

bind weighted_lru_victim_select wlru_checker u_wlru_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .i_kind           (i_kind),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_victim_way     (o_victim_way),
    .o_victim_invalid (o_victim_invalid)
);

// ===== test/wlru_victim_checker.sv =====
// Checker for the weighted LRU victim selector: tracks set state, predicts victims, compares.
`timescale 1ns / 1ps

module wlru_victim_checker
    import wlru_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [KIND_W-1:0]     i_kind,
    input  logic [SET_IN_W-1:0]   i_set_index,
    input  logic [WAY_IN_W-1:0]   i_way_index,
    input  logic [OCC_W-1:0]      i_occupancy,
    input  logic [UP_W-1:0]       i_upper_present,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [WAY_IN_W-1:0]   i_victim_way,
    input  logic                  i_victim_invalid,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [LEVEL_W-1:0]    i_cfg_hier_level,
    output int                    o_errors,
    output int                    o_pending,
    output int                    o_picks
);

    typedef struct packed {
        logic [SET_IN_W-1:0] set_no;
        logic [WAY_IN_W-1:0] way;
        logic                invalid;
    } t_victim;

    localparam logic [1:0] TIER_INVALID = 2'd0;
    localparam logic [1:0] TIER_ABSENT  = 2'd1;
    localparam logic [1:0] TIER_PRESENT = 2'd2;
    localparam int         REPORT_MAX   = 10;

    logic [STAMP_W-1:0]     stamp_mem  [NUM_SETS*NUM_WAYS];
    logic [WEIGHT_BITS-1:0] weight_mem [NUM_SETS*NUM_WAYS];
    logic [STAMP_W-1:0]     stamp_ctr;
    logic [LEVEL_W-1:0]     level;
    t_victim                expected_picks [$];
    int                     errors;
    int                     picks;

    // Lowest invalid way in standard mode, else by (tier, weight, stamp); low way wins a tie.
    function automatic t_victim pick_victim(input int unsigned set_no,
                                            input logic [UP_W-1:0] upper);
        t_victim                pick;
        int unsigned            base;
        int                     best;
        logic                   found;
        logic [1:0]             tier;
        logic [1:0]             best_tier;
        logic [WEIGHT_BITS-1:0] wt;
        logic [WEIGHT_BITS-1:0] best_wt;
        logic [STAMP_W-1:0]     stamp;
        logic [STAMP_W-1:0]     best_stamp;
        base       = set_no * NUM_WAYS;
        best       = 0;
        found      = 1'b0;
        best_tier  = TIER_INVALID;
        best_wt    = '0;
        best_stamp = '0;
        if (level != LEVEL_TWO) begin
            for (int w = 0; w < NUM_WAYS; w++) begin
                if (!found && stamp_mem[base + w] == '0) begin
                    best  = w;
                    found = 1'b1;
                end
            end
        end
        if (!found) begin
            for (int w = 0; w < NUM_WAYS; w++) begin
                stamp = stamp_mem[base + w];
                wt    = weight_mem[base + w];
                // standard mode puts every way in one tier
                if (level != LEVEL_TWO || stamp == '0)
                    tier = TIER_INVALID;
                else if (w < UP_W && upper[w])
                    tier = TIER_PRESENT;
                else
                    tier = TIER_ABSENT;
                if (w == 0 || tier < best_tier ||
                    (tier == best_tier && (wt < best_wt ||
                     (wt == best_wt && stamp < best_stamp)))) begin
                    best       = w;
                    best_tier  = tier;
                    best_wt    = wt;
                    best_stamp = stamp;
                end
            end
        end
        pick.set_no  = SET_IN_W'(set_no);
        pick.way     = WAY_IN_W'(best);
        pick.invalid = (stamp_mem[base + best] == '0);
        return pick;
    endfunction

    // Sample at the falling edge: every handshake seen here completes at the next rising edge.
    always @(negedge i_clk) begin : observe
        t_victim     want;
        int unsigned set_no;
        int unsigned slot;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SETS*NUM_WAYS; i++) begin
                stamp_mem[i]  = '0;
                weight_mem[i] = '0;
            end
            stamp_ctr = STAMP_W'(1);
            level     = LEVEL_ONE;
            expected_picks.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                level = i_cfg_hier_level;

            if (i_out_valid && i_out_ready) begin
                if (expected_picks.size() == 0) begin
                    errors++;
                    if (errors <= REPORT_MAX)
                        $display("%0t: unexpected result way %0d invalid %0b",
                                 $realtime, i_victim_way, i_victim_invalid);
                end else begin
                    want = expected_picks.pop_front();
                    picks++;
                    if (i_victim_way !== want.way || i_victim_invalid !== want.invalid) begin
                        errors++;
                        if (errors <= REPORT_MAX)
                            $display({"%0t: set %0d victim mismatch: expected way %0d ",
                                      "invalid %0b, got way %0d invalid %0b"},
                                     $realtime, want.set_no, want.way, want.invalid,
                                     i_victim_way, i_victim_invalid);
                    end
                end
            end

            if (i_in_valid && i_in_ready) begin
                set_no = i_set_index % NUM_SETS;
                slot   = set_no * NUM_WAYS + i_way_index;
                case (i_kind)
                    KIND_TOUCH: begin
                        if (i_way_index < NUM_WAYS) begin
                            stamp_mem[slot]  = stamp_ctr;
                            weight_mem[slot] = i_occupancy[WEIGHT_BITS-1:0];
                            if (stamp_ctr != '1)
                                stamp_ctr++;
                        end
                    end
                    KIND_INVAL: begin
                        // weight stays; only the stamp goes
                        if (i_way_index < NUM_WAYS)
                            stamp_mem[slot] = '0;
                    end
                    KIND_VICTIM: begin
                        expected_picks = {expected_picks,
                                          pick_victim(set_no, i_upper_present)};
                    end
                    default: begin
                        // unused code: drop it
                    end
                endcase
            end
        end
        o_errors  = errors;
        o_pending = expected_picks.size();
        o_picks   = picks;
    end

endmodule

// ===== test/tb_weighted_lru_victim_select.sv =====
// Testbench top for the weighted LRU victim selector: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_weighted_lru_victim_select;
    import wlru_pkg::*;

    // Codes the package leaves unnamed.
    localparam logic [KIND_W-1:0]  KIND_UNUSED = 2'd3;
    localparam logic [LEVEL_W-1:0] LEVEL_ZERO  = 2'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_THREE = 2'd3;

    // Margin to leave after the last result.
    localparam int SETTLE_CYCLES = 16;
    // Cycle limit that ends a hung run, well above the slowest correct run.
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_ITEMS   = 160;
    localparam int NUM_PHASES    = 5;

    typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_QUARTER, SINK_SPARSE} t_sink_mode;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  req_valid     = 1'b0;
    logic [KIND_W-1:0]     req_kind      = KIND_TOUCH;
    logic [SET_IN_W-1:0]   req_set       = '0;
    logic [WAY_IN_W-1:0]   req_way       = '0;
    logic [OCC_W-1:0]      req_occ       = '0;
    logic [UP_W-1:0]       req_upper     = '0;
    logic                  pick_ready    = 1'b0;
    logic                  cfg_valid     = 1'b0;
    logic [LEVEL_W-1:0]    cfg_level     = LEVEL_ONE;

    logic                  req_ready;
    logic                  pick_valid;
    logic [WAY_IN_W-1:0]   pick_way;
    logic                  pick_invalid;
    logic                  cfg_ready;

    int                    errors;
    int                    pending;
    int                    picks;

    int                    cycle_cnt     = 0;
    t_sink_mode            sink_mode     = SINK_OPEN;
    int                    burst_left    = 0;
    int                    n_touch       = 0;
    int                    n_inval       = 0;
    int                    n_victim      = 0;
    int                    n_unused      = 0;
    int                    n_level_writes = 0;

    // Weights for the directed fill of set 63: ties at weight 0 on ways 2, 3 and 6.
    logic [OCC_W-1:0]      fill_weights [NUM_WAYS] =
        '{8'd255, 8'd7, 8'd0, 8'd0, 8'd128, 8'd255, 8'd0, 8'd1};
    logic [LEVEL_W-1:0]    phase_levels [NUM_PHASES] =
        '{LEVEL_ZERO, LEVEL_THREE, LEVEL_TWO, LEVEL_ONE, LEVEL_TWO};

    always #6 clk = ~clk;

    weighted_lru_victim_select dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (req_valid),
        .o_in_ready        (req_ready),
        .i_kind            (req_kind),
        .i_set_index       (req_set),
        .i_way_index       (req_way),
        .i_occupancy       (req_occ),
        .i_upper_present   (req_upper),
        .o_out_valid       (pick_valid),
        .i_out_ready       (pick_ready),
        .o_victim_way      (pick_way),
        .o_victim_invalid  (pick_invalid),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_hier_level  (cfg_level)
    );

    wlru_victim_checker checker_i (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (req_valid),
        .i_in_ready        (req_ready),
        .i_kind            (req_kind),
        .i_set_index       (req_set),
        .i_way_index       (req_way),
        .i_occupancy       (req_occ),
        .i_upper_present   (req_upper),
        .i_out_valid       (pick_valid),
        .i_out_ready       (pick_ready),
        .i_victim_way      (pick_way),
        .i_victim_invalid  (pick_invalid),
        .i_cfg_valid       (cfg_valid),
        .i_cfg_ready       (cfg_ready),
        .i_cfg_hier_level  (cfg_level),
        .o_errors          (errors),
        .o_pending         (pending),
        .o_picks           (picks)
    );

    // Result sink: draws a random stall pattern, open, coin-flip, quarter or sparse.
    // The same block keeps the cycle count and ends a hung run.
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt % 64 == 0)
            sink_mode <= t_sink_mode'($urandom_range(0, 3));
        case (sink_mode)
            SINK_OPEN:    pick_ready <= 1'b1;
            SINK_COIN:    pick_ready <= ($urandom_range(0, 1) == 1);
            SINK_QUARTER: pick_ready <= (cycle_cnt[1:0] == 2'd0);
            default:      pick_ready <= (cycle_cnt % 13 == 0);
        endcase
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected", cycle_cnt, pending);
            $display("tb_weighted_lru_victim_select: done, errors");
            $finish;
        end
    end

    // Present one request and hold it until accepted. Bursts of back-to-back requests
    // are separated by random gaps; a quarter of the bursts start with no gap at all.
    // Called and returning right after a rising edge.
    task automatic issue_request(input logic [KIND_W-1:0]   kind,
                                 input logic [SET_IN_W-1:0] set_no,
                                 input logic [WAY_IN_W-1:0] way,
                                 input logic [OCC_W-1:0]    occ,
                                 input logic [UP_W-1:0]     upper);
        int gap;
        bit hit;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            if (gap > 0) begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_valid <= 1'b1;
        req_kind  <= kind;
        req_set   <= set_no;
        req_way   <= way;
        req_occ   <= occ;
        req_upper <= upper;
        // ready only moves at rising edges, so its value at the falling edge decides
        forever begin
            @(negedge clk);
            hit = req_ready;
            @(posedge clk);
            if (hit)
                break;
        end
        case (kind)
            KIND_TOUCH:  n_touch++;
            KIND_INVAL:  n_inval++;
            KIND_VICTIM: n_victim++;
            default:     n_unused++;
        endcase
    endtask

    // Drop valid after the last request of a stretch.
    task automatic close_burst();
        req_valid <= 1'b0;
        burst_left = 0;
    endtask

    // Wait until every expected result has arrived, then let the last touch settle.
    task automatic drain();
        do
            @(posedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_level(input logic [LEVEL_W-1:0] lvl);
        bit hit;
        cfg_valid <= 1'b1;
        cfg_level <= lvl;
        forever begin
            @(negedge clk);
            hit = cfg_ready;
            @(posedge clk);
            if (hit)
                break;
        end
        cfg_valid <= 1'b0;
        n_level_writes++;
    endtask

    // Random traffic over a handful of hot sets so that victims see well-populated state.
    // Low weights dominate to force weight ties; the invalidate rate varies per phase so
    // some phases run mostly full sets and others keep many holes.
    task automatic random_phase(input int count);
        logic [SET_IN_W-1:0] hot_sets [4];
        logic [KIND_W-1:0]   kind;
        logic [SET_IN_W-1:0] set_no;
        logic [OCC_W-1:0]    occ;
        int                  inval_pct;
        int                  r;
        int                  done_cnt;
        foreach (hot_sets[i])
            hot_sets[i] = SET_IN_W'($urandom_range(0, NUM_SETS - 1));
        inval_pct = $urandom_range(3, 22);
        done_cnt  = 0;
        while (done_cnt < count) begin
            r = $urandom_range(0, 99);
            if (r < 45)
                kind = KIND_TOUCH;
            else if (r < 45 + inval_pct)
                kind = KIND_INVAL;
            else if (r < 96)
                kind = KIND_VICTIM;
            else
                kind = KIND_UNUSED;
            if ($urandom_range(0, 4) != 0)
                set_no = hot_sets[$urandom_range(0, 3)];
            else
                set_no = SET_IN_W'($urandom_range(0, NUM_SETS - 1));
            if ($urandom_range(0, 9) < 6)
                occ = OCC_W'($urandom_range(0, 3));
            else
                occ = OCC_W'($urandom_range(0, 255));
            issue_request(kind, set_no, WAY_IN_W'($urandom_range(0, NUM_WAYS - 1)), occ,
                          UP_W'($urandom_range(0, 255)));
            // ignored requests do not count toward the phase
            if (kind != KIND_UNUSED)
                done_cnt++;
        end
        close_burst();
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Standard mode from reset. A fresh set is all invalid: expect way 0.
        issue_request(KIND_VICTIM, 6'd0, 3'd0, 8'd0, 8'h00);
        // Fill set 63, oldest first.
        for (int w = 0; w < NUM_WAYS; w++)
            issue_request(KIND_TOUCH, 6'd63, WAY_IN_W'(w), fill_weights[w], 8'h00);
        // Full set: lowest weight, oldest of the tied ways wins.
        issue_request(KIND_VICTIM, 6'd63, 3'd0, 8'd0, 8'hFF);
        // A hole beats any weight in standard mode.
        issue_request(KIND_INVAL, 6'd63, 3'd5, 8'd0, 8'h00);
        issue_request(KIND_VICTIM, 6'd63, 3'd0, 8'd0, 8'h00);
        // Unused code with set, occupancy and upper mask at their top: no result, no state change.
        issue_request(KIND_UNUSED, 6'd63, 3'd0, 8'hFF, 8'hFF);
        issue_request(KIND_VICTIM, 6'd63, 3'd7, 8'hFF, 8'h00);
        close_burst();
        drain();

        // Level-two mode on the same set.
        write_level(LEVEL_TWO);
        issue_request(KIND_VICTIM, 6'd63, 3'd0, 8'd0, 8'hFF);
        issue_request(KIND_TOUCH, 6'd63, 3'd5, 8'd9, 8'h00);
        // every way present, then every way absent: same tier throughout
        issue_request(KIND_VICTIM, 6'd63, 3'd0, 8'd0, 8'hFF);
        issue_request(KIND_VICTIM, 6'd63, 3'd0, 8'd0, 8'h00);
        // only way 3 absent from the upper cache: it goes despite other ties
        issue_request(KIND_VICTIM, 6'd63, 3'd0, 8'd0, 8'hF7);
        // invalidated ways keep their weights and are ranked by them
        issue_request(KIND_INVAL, 6'd63, 3'd7, 8'd0, 8'h00);
        issue_request(KIND_INVAL, 6'd63, 3'd1, 8'd0, 8'h00);
        issue_request(KIND_VICTIM, 6'd63, 3'd0, 8'd0, 8'hAA);
        issue_request(KIND_VICTIM, 6'd0, 3'd0, 8'd0, 8'h55);
        close_burst();

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            write_level(phase_levels[p]);
            random_phase(PHASE_ITEMS);
        end
        drain();

        $display("covered %0d touches, %0d invalidates, %0d victim requests, %0d unused codes",
                 n_touch, n_inval, n_victim, n_unused);
        $display("%0d victim results checked across %0d hierarchy level writes (levels 0 to 3)",
                 picks, n_level_writes);
        if (errors == 0 && pending == 0)
            $display("tb_weighted_lru_victim_select: done, clean");
        else
            $display("tb_weighted_lru_victim_select: done, errors");
        $finish;
    end

endmodule
